/* rtl/core/cfb_pkg.sv */
// cfb_pkg: shared types, constants and the byte-wise crc update for the frame builder
// depends on nothing; used by every module under rtl/core
package cfb_pkg;

	localparam logic [7:0]  SYNC_HI       = 8'hA5;
	localparam logic [7:0]  SYNC_LO       = 8'h5A;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// byte positions within the sequence a command produces
	localparam logic [2:0] POS_SYNC_HI = 3'd0;
	localparam logic [2:0] POS_SYNC_LO = 3'd1;
	localparam logic [2:0] POS_TYPE    = 3'd2;
	localparam logic [2:0] POS_LEN_HI  = 3'd3;
	localparam logic [2:0] POS_LEN_LO  = 3'd4;
	localparam logic [2:0] POS_CRC_LO  = 3'd5;
	localparam logic [2:0] POS_CRC_HI  = 3'd6;
	localparam logic [2:0] POS_DATA    = 3'd0;
	localparam logic [2:0] POS_DCRC_LO = 3'd1;
	localparam logic [2:0] POS_DCRC_HI = 3'd2;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  type_byte;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
		logic       error;
	} result_t;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_DATA,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  byte_val;   // type byte on start, payload byte on data
		logic [15:0] length;
		logic [15:0] crc_init;
		logic        last;       // final payload byte of the frame
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/cfb_queue.sv */
// cfb_queue: small command fifo between the classifying front and the byte sequencer
// depends on cfb_pkg for cmd_t and the queue depth
module cfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfb_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output cfb_pkg::cmd_t  head,
	output logic           empty
);

	cfb_pkg::cmd_t                  entry_q [cfb_pkg::QUEUE_DEPTH];
	logic [cfb_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [cfb_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [cfb_pkg::QUEUE_CW-1:0]   count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == cfb_pkg::QUEUE_CW'(cfb_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + cfb_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + cfb_pkg::QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + cfb_pkg::QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - cfb_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule

/* rtl/core/cfb_front.sv */
// cfb_front: accepts input requests, tracks the open frame and turns each request into a command
// depends on cfb_pkg for item_t, cmd_t and the operation codes
module cfb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           accept,
	input  cfb_pkg::item_t item,
	output cfb_pkg::cmd_t  cmd
);

	logic [15:0] crc_init_val_q;
	logic        frame_open_q;
	logic [15:0] bytes_remaining_q;
	logic        last_byte;

	assign last_byte = (bytes_remaining_q == 16'd1);

	// config register, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_val_q <= '0;
		end else if (cfg_we) begin
			crc_init_val_q <= cfg_wdata;
		end
	end

	always_comb begin
		cmd.byte_val = item.data_byte;
		cmd.length   = item.payload_length;
		cmd.crc_init = crc_init_val_q;
		cmd.last     = 1'b0;
		cmd.kind     = cfb_pkg::CMD_ERROR;
		case (item.operation)
			cfb_pkg::OP_START: begin
				cmd.kind     = cfb_pkg::CMD_START;
				cmd.byte_val = item.type_byte;
			end
			cfb_pkg::OP_PAYLOAD: begin
				if (frame_open_q) begin
					cmd.kind = cfb_pkg::CMD_DATA;
					cmd.last = last_byte;
				end
			end
			default: begin
				cmd.kind = cfb_pkg::CMD_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q      <= 1'b0;
			bytes_remaining_q <= '0;
		end else if (accept) begin
			if (item.operation == cfb_pkg::OP_START) begin
				frame_open_q      <= (item.payload_length != 16'd0);
				bytes_remaining_q <= item.payload_length;
			end else if (frame_open_q) begin
				bytes_remaining_q <= bytes_remaining_q - 16'd1;
				if (last_byte) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/core/cfb_back.sv */
// cfb_back: byte sequencer that plays out each queued command and keeps the running crc
// depends on cfb_pkg for cmd_t, result_t, byte positions and crc_byte
module cfb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cfb_pkg::cmd_t    head,
	input  logic             head_valid,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output cfb_pkg::result_t result
);

	logic [2:0]       pos_q;
	logic [15:0]      crc_q;
	logic             result_valid_q;
	cfb_pkg::result_t result_q;

	logic             advance;
	logic             emit;
	logic [2:0]       final_pos;
	logic             is_final;
	logic [7:0]       emit_byte;
	logic             emit_end;
	logic             crc_feed;
	logic [15:0]      crc_base;

	assign advance = !result_valid_q || !result_stall;
	assign emit    = advance && head_valid;
	assign is_final = (pos_q == final_pos);
	assign pop     = emit && is_final;

	always_comb begin
		final_pos = cfb_pkg::POS_DATA;
		emit_byte = 8'h00;
		emit_end  = 1'b0;
		crc_feed  = 1'b0;
		crc_base  = crc_q;
		case (head.kind)
			cfb_pkg::CMD_START: begin
				final_pos = (head.length == 16'd0) ? cfb_pkg::POS_CRC_HI : cfb_pkg::POS_LEN_LO;
				crc_feed  = (pos_q <= cfb_pkg::POS_LEN_LO);
				if (pos_q == cfb_pkg::POS_SYNC_HI) begin
					crc_base = head.crc_init;
				end
				case (pos_q)
					cfb_pkg::POS_SYNC_HI: emit_byte = cfb_pkg::SYNC_HI;
					cfb_pkg::POS_SYNC_LO: emit_byte = cfb_pkg::SYNC_LO;
					cfb_pkg::POS_TYPE:    emit_byte = head.byte_val;
					cfb_pkg::POS_LEN_HI:  emit_byte = head.length[15:8];
					cfb_pkg::POS_LEN_LO:  emit_byte = head.length[7:0];
					cfb_pkg::POS_CRC_LO:  emit_byte = 8'(crc_q & cfb_pkg::LOW_BYTE_MASK);
					cfb_pkg::POS_CRC_HI: begin
						emit_byte = crc_q[15:8];
						emit_end  = 1'b1;
					end
					default: emit_byte = 8'h00;
				endcase
			end
			cfb_pkg::CMD_DATA: begin
				final_pos = head.last ? cfb_pkg::POS_DCRC_HI : cfb_pkg::POS_DATA;
				crc_feed  = (pos_q == cfb_pkg::POS_DATA);
				case (pos_q)
					cfb_pkg::POS_DATA:    emit_byte = head.byte_val;
					cfb_pkg::POS_DCRC_LO: emit_byte = 8'(crc_q & cfb_pkg::LOW_BYTE_MASK);
					cfb_pkg::POS_DCRC_HI: begin
						emit_byte = crc_q[15:8];
						emit_end  = 1'b1;
					end
					default: emit_byte = 8'h00;
				endcase
			end
			default: begin
				final_pos = cfb_pkg::POS_DATA;
				emit_byte = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			crc_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
			pos_q          <= is_final ? 3'd0 : pos_q + 3'd1;
			if (crc_feed) begin
				crc_q <= cfb_pkg::crc_byte(crc_base, emit_byte);
			end
		end else if (advance) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register, no reset on payload
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.out_byte  <= emit_byte;
			result_q.frame_end <= emit_end;
			result_q.run_last  <= is_final;
			result_q.error     <= (head.kind == cfb_pkg::CMD_ERROR);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/crc16_frame_builder.sv */
// crc16_frame_builder: top level, front classifier, command queue and byte sequencer
// depends on cfb_pkg, cfb_front, cfb_queue and cfb_back
//
// Builds frames A5 5A, type, length (big-endian), payload, crc-16 (poly A001, reflected,
// low byte first, seeded from cfg_wdata, covering header and payload). An input request is
// taken whenever the four-entry command queue has room, so requests may arrive back to
// back. Results leave one byte per cycle from the output register of the byte sequencer
// while result_stall is low and a command is queued: a start request yields five bytes of
// output (seven with an empty payload), a payload byte one (three for the last byte of a
// frame, which adds the crc), a payload byte with no frame open one. The sustained rate is
// therefore set by the output byte count. A taken request is written into the command
// queue and its first byte then into the output register, which drives result_valid.
module crc16_frame_builder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             item_valid,
	output logic             item_stall,
	input  cfb_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output cfb_pkg::result_t result
);

	cfb_pkg::cmd_t cmd;
	cfb_pkg::cmd_t head;
	logic          accept;
	logic          full;
	logic          empty;
	logic          pop;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	cfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.cmd       (cmd)
	);

	cfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	cfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// a frame only ends on the last byte of its request
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.frame_end || result.run_last))
		else $error("frame end without run last");

	// an error result is a lone zero byte
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error) |->
		(result.out_byte == 8'h00 && result.run_last && !result.frame_end))
		else $error("malformed error result");

	// nothing comes out of an empty pipe
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		($past(empty) && empty && !$past(result_valid)) |-> !result_valid)
		else $error("result with no queued command");
`endif

endmodule

/* dv/crc16_frame_builder_chk.sv */
// crc16_frame_builder_chk: watches the request and result channels of the frame builder,
// predicts every frame byte with its own crc-16 model and compares in order
// depends on cfb_pkg for the payload structs and framing constants
module crc16_frame_builder_chk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             item_valid,
	input  logic             item_stall,
	input  cfb_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  cfb_pkg::result_t result,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]      crc_seed;
	logic [15:0]      crc_acc;
	logic [15:0]      bytes_left;
	logic             in_frame;
	cfb_pkg::result_t frame_bytes_due[$];
	cfb_pkg::result_t want;

	initial begin
		mismatches = 0;
	end

	function automatic logic [15:0] crc16_arc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ cfb_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic fe, input logic rl, input logic er);
		cfb_pkg::result_t r;
		r.out_byte  = b;
		r.frame_end = fe;
		r.run_last  = rl;
		r.error     = er;
		frame_bytes_due.push_back(r);
	endtask

	task automatic close_with_crc();
		queue_byte(crc_acc[7:0], 1'b0, 1'b0, 1'b0);
		queue_byte(crc_acc[15:8], 1'b1, 1'b1, 1'b0);
		in_frame   = 1'b0;
		bytes_left = '0;
	endtask

	task automatic build_frame_bytes(input cfb_pkg::item_t req);
		logic [7:0] hdr [5];
		hdr = '{cfb_pkg::SYNC_HI, cfb_pkg::SYNC_LO, req.type_byte, req.payload_length[15:8],
			req.payload_length[7:0]};
		if (req.operation == cfb_pkg::OP_START) begin
			// seed is latched here, so a write mid-frame waits for the next start
			crc_acc = crc_seed;
			for (int k = 0; k < 5; k++) begin
				crc_acc = crc16_arc_step(crc_acc, hdr[k]);
				queue_byte(hdr[k], 1'b0, (k == 4 && req.payload_length != 16'd0), 1'b0);
			end
			if (req.payload_length == 16'd0) begin
				close_with_crc();
			end else begin
				in_frame   = 1'b1;
				bytes_left = req.payload_length;
			end
		end else if (!in_frame) begin
			queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
		end else begin
			crc_acc    = crc16_arc_step(crc_acc, req.data_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0) begin
				queue_byte(req.data_byte, 1'b0, 1'b0, 1'b0);
				close_with_crc();
			end else begin
				queue_byte(req.data_byte, 1'b0, 1'b1, 1'b0);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed   = '0;
			crc_acc    = '0;
			bytes_left = '0;
			in_frame   = 1'b0;
			frame_bytes_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				crc_seed = cfg_wdata;
			end
			// results first: nothing leaves in the cycle its request is taken
			if (result_valid && !result_stall) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("result %02h with nothing expected",
						result.out_byte));
				end else begin
					want = frame_bytes_due.pop_front();
					if (result.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte got %02h want %02h",
							result.out_byte, want.out_byte));
					if (result.frame_end !== want.frame_end)
						report_mismatch($sformatf("frame_end got %b want %b",
							result.frame_end, want.frame_end));
					if (result.run_last !== want.run_last)
						report_mismatch($sformatf("run_last got %b want %b",
							result.run_last, want.run_last));
					if (result.error !== want.error)
						report_mismatch($sformatf("error got %b want %b",
							result.error, want.error));
				end
			end
			if (item_valid && !item_stall) begin
				build_frame_bytes(item);
			end
			pending <= frame_bytes_due.size();
		end
	end

endmodule

/* dv/crc16_frame_builder_tb.sv */
// crc16_frame_builder_tb: clock, reset, crc seed writes and request stimulus for the
// frame builder; the checker beside the block predicts and compares
// depends on cfb_pkg, crc16_frame_builder and crc16_frame_builder_chk
module crc16_frame_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [15:0]      cfg_wdata;
	logic             item_valid;
	logic             item_stall;
	cfb_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	cfb_pkg::result_t result;
	int               mismatches;
	int               pending;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int requests_sent;

	crc16_frame_builder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	crc16_frame_builder_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = 80;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic cfb_pkg::item_t start_req(input logic [7:0] t, input logic [15:0] len);
		cfb_pkg::item_t r;
		r.operation      = cfb_pkg::OP_START;
		r.type_byte      = t;
		r.payload_length = len;
		r.data_byte      = 8'($urandom);
		return r;
	endfunction

	function automatic cfb_pkg::item_t byte_req(input logic [7:0] d);
		cfb_pkg::item_t r;
		r.operation      = cfb_pkg::OP_PAYLOAD;
		r.type_byte      = 8'($urandom);
		r.payload_length = 16'($urandom);
		r.data_byte      = d;
		return r;
	endfunction

	task automatic push_request(input cfb_pkg::item_t req);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (item_stall);
		requests_sent++;
	endtask

	task automatic write_crc_seed(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		int stop_at;
		int r;
		int len;
		stop_at = requests_sent + n;
		while (requests_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 75) begin
				// complete frame, mostly short payloads
				len = ($urandom_range(7) == 0) ? 0 : $urandom_range(8, 1);
				if ($urandom_range(19) == 0) len = $urandom_range(40, 9);
				push_request(start_req(8'($urandom), 16'(len)));
				repeat (len) push_request(byte_req(8'($urandom)));
			end else if (r < 88) begin
				// frame left open, abandoned by whatever start comes next
				push_request(start_req(8'($urandom), 16'($urandom_range(65535))));
				repeat ($urandom_range(3)) push_request(byte_req(8'($urandom)));
			end else begin
				repeat ($urandom_range(2, 1)) push_request(byte_req(8'($urandom)));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		item_valid    = 1'b0;
		item          = '0;
		tx_idle_pct   = 18;
		rx_idle_pct   = 75;
		hold_request  = 0;
		requests_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_crc_seed(16'h0000);
		push_request(byte_req(8'h00));          // stray byte straight after reset
		push_request(start_req(8'h00, 16'h0000));
		push_request(start_req(8'hFF, 16'h0001));
		push_request(byte_req(8'hFF));
		push_request(start_req(8'h5A, 16'h0002));
		push_request(byte_req(8'h00));
		push_request(byte_req(8'h80));
		push_request(byte_req(8'hFF));          // stray byte after a closed frame
		drain();

		write_crc_seed(16'hFFFF);
		push_request(start_req(8'hA5, 16'h0000));
		push_request(start_req(8'h01, 16'hFFFF));
		push_request(byte_req(8'h12));
		push_request(byte_req(8'h34));
		push_request(start_req(8'h80, 16'h8000)); // abandons the open frame
		push_request(byte_req(8'h55));
		push_request(start_req(8'h7F, 16'h0003));
		push_request(byte_req(8'hAA));
		push_request(byte_req(8'h55));
		push_request(byte_req(8'h01));
		push_request(start_req(8'h3C, 16'h0100));
		push_request(byte_req(8'hC3));
		drain();

		// a frame may still be open here, the new seed applies from its next start
		write_crc_seed(16'($urandom));
		run_random(160);
		drain();

		tx_idle_pct = 75;
		rx_idle_pct = 18;
		write_crc_seed(16'hFFFF);
		run_random(160);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_crc_seed(16'h0000);
		hold_request = 1;
		run_random(80);
		drain();

		write_crc_seed(16'($urandom));
		run_random(80);
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
